// File: hdl/ialu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ialu_pkg;

    localparam int unsigned DataWidth = 32;
    localparam int unsigned CntWidth  = $clog2(DataWidth);

    // operation codes carried in s_tuser
    typedef enum logic [3:0] {
        OP_ADD   = 4'd0,
        OP_ADDU  = 4'd1,
        OP_SUB   = 4'd2,
        OP_SUBU  = 4'd3,
        OP_AND   = 4'd4,
        OP_OR    = 4'd5,
        OP_XOR   = 4'd6,
        OP_NOR   = 4'd7,
        OP_SLT   = 4'd8,
        OP_SLTU  = 4'd9,
        OP_MULT  = 4'd10,
        OP_MULTU = 4'd11,
        OP_DIV   = 4'd12,
        OP_DIVU  = 4'd13
    } op_t;

    // status codes carried in m_tuser
    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_OVERFLOW = 2'd1,
        STS_DIVZERO  = 2'd2
    } sts_t;

    // combinational alu answer
    typedef struct packed {
        logic [DataWidth-1:0] result;
        sts_t                 status;
    } alu_rsp_t;

    // request into the multiply/divide unit
    typedef struct packed {
        logic                 start;
        logic                 is_div;
        logic                 is_signed;
        logic [DataWidth-1:0] a;
        logic [DataWidth-1:0] b;
    } md_req_t;

    // answer from the multiply/divide unit
    typedef struct packed {
        logic                 done;
        logic [DataWidth-1:0] hi;
        logic [DataWidth-1:0] lo;
    } md_rsp_t;

endpackage

`default_nettype wire

// File: hdl/ialu_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module ialu_alu (
    input  wire ialu_pkg::op_t              op,
    input  wire [ialu_pkg::DataWidth-1:0]   a,
    input  wire [ialu_pkg::DataWidth-1:0]   b,
    output ialu_pkg::alu_rsp_t              rsp
);

    localparam int unsigned W = ialu_pkg::DataWidth;

    logic [W:0]   sum;
    logic [W:0]   diff;
    logic         ltu;
    logic         lts;
    logic [W-1:0] lt_u_word;
    logic [W-1:0] lt_s_word;

    // one adder and one subtractor, borrow gives unsigned less-than
    assign sum  = {1'b0, a} + {1'b0, b};
    assign diff = {1'b0, a} - {1'b0, b};
    assign ltu  = diff[W];
    assign lts  = (a[W-1] ^ b[W-1]) ? a[W-1] : ltu;
    assign lt_u_word = {{(W-1){1'b0}}, ltu};
    assign lt_s_word = {{(W-1){1'b0}}, lts};

    // operation select
    always_comb begin
        rsp.result = '0;
        rsp.status = ialu_pkg::STS_OK;
        case (op)
            ialu_pkg::OP_ADD: begin
                if (((a[W-1] ^ sum[W-1]) & (b[W-1] ^ sum[W-1])) == 1'b1) begin
                    rsp.status = ialu_pkg::STS_OVERFLOW;
                end else begin
                    rsp.result = sum[W-1:0];
                end
            end
            ialu_pkg::OP_ADDU: rsp.result = sum[W-1:0];
            ialu_pkg::OP_SUB: begin
                if (((a[W-1] ^ b[W-1]) & (a[W-1] ^ diff[W-1])) == 1'b1) begin
                    rsp.status = ialu_pkg::STS_OVERFLOW;
                end else begin
                    rsp.result = diff[W-1:0];
                end
            end
            ialu_pkg::OP_SUBU: rsp.result = diff[W-1:0];
            ialu_pkg::OP_AND:  rsp.result = a & b;
            ialu_pkg::OP_OR:   rsp.result = a | b;
            ialu_pkg::OP_XOR:  rsp.result = a ^ b;
            ialu_pkg::OP_NOR:  rsp.result = ~(a | b);
            ialu_pkg::OP_SLT:  rsp.result = lt_s_word;
            ialu_pkg::OP_SLTU: rsp.result = lt_u_word;
            ialu_pkg::OP_DIV, ialu_pkg::OP_DIVU: begin
                if (b == '0) begin
                    rsp.status = ialu_pkg::STS_DIVZERO;
                end
            end
            default: begin
                rsp.result = '0;
                rsp.status = ialu_pkg::STS_OK;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hdl/ialu_muldiv.sv
`timescale 1ns / 1ps
`default_nettype none

module ialu_muldiv (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire ialu_pkg::md_req_t req,
    output ialu_pkg::md_rsp_t    rsp
);

    localparam int unsigned W = ialu_pkg::DataWidth;
    localparam int unsigned C = ialu_pkg::CntWidth;
    localparam logic [C-1:0] LastCnt = C'(W - 1);

    typedef enum logic [2:0] {
        MD_IDLE = 3'b001,
        MD_ITER = 3'b010,
        MD_FIX  = 3'b100
    } md_state_t;

    md_state_t    state_reg, state_next;
    logic [W-1:0] hi_reg, hi_next;
    logic [W-1:0] lo_reg, lo_next;
    logic [W-1:0] b_reg, b_next;
    logic [C-1:0] cnt_reg, cnt_next;
    logic         is_div_reg, is_div_next;
    logic         neg_q_reg, neg_q_next;
    logic         neg_r_reg, neg_r_next;
    logic         done_reg, done_next;

    logic [W-1:0]   mag_a;
    logic [W-1:0]   mag_b;
    logic [W:0]     x_op;
    logic [W:0]     y_op;
    logic [W+1:0]   total;
    logic           ge;
    logic [2*W-1:0] prod_neg;

    // operand magnitudes for the signed forms
    assign mag_a = (req.is_signed && req.a[W-1]) ? (~req.a + W'(1)) : req.a;
    assign mag_b = (req.is_signed && req.b[W-1]) ? (~req.b + W'(1)) : req.b;

    // shared adder: add for shift-add multiply, subtract for restoring divide
    assign x_op  = is_div_reg ? {hi_reg, lo_reg[W-1]} : {1'b0, hi_reg};
    assign y_op  = {1'b0, (is_div_reg || lo_reg[0]) ? b_reg : '0};
    assign total = {1'b0, x_op} + {1'b0, (is_div_reg ? ~y_op : y_op)}
                 + {{(W+1){1'b0}}, is_div_reg};
    assign ge    = total[W+1];

    assign prod_neg = ~{hi_reg, lo_reg} + {{(2*W-1){1'b0}}, 1'b1};

    // sequencer
    always_comb begin
        state_next  = state_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        b_next      = b_reg;
        cnt_next    = cnt_reg;
        is_div_next = is_div_reg;
        neg_q_next  = neg_q_reg;
        neg_r_next  = neg_r_reg;
        done_next   = 1'b0;
        case (state_reg)
            MD_IDLE: begin
                if (req.start) begin
                    hi_next     = '0;
                    lo_next     = mag_a;
                    b_next      = mag_b;
                    cnt_next    = '0;
                    is_div_next = req.is_div;
                    neg_q_next  = req.is_signed & (req.a[W-1] ^ req.b[W-1]);
                    neg_r_next  = req.is_signed & req.a[W-1];
                    state_next  = MD_ITER;
                end
            end
            MD_ITER: begin
                if (is_div_reg) begin
                    hi_next = ge ? total[W-1:0] : x_op[W-1:0];
                    lo_next = {lo_reg[W-2:0], ge};
                end else begin
                    hi_next = total[W:1];
                    lo_next = {total[0], lo_reg[W-1:1]};
                end
                cnt_next = cnt_reg + C'(1);
                if (cnt_reg == LastCnt) begin
                    state_next = MD_FIX;
                end
            end
            MD_FIX: begin
                // sign correction of product, quotient and remainder
                if (is_div_reg) begin
                    if (neg_q_reg) begin
                        lo_next = ~lo_reg + W'(1);
                    end
                    if (neg_r_reg) begin
                        hi_next = ~hi_reg + W'(1);
                    end
                end else if (neg_q_reg) begin
                    hi_next = prod_neg[2*W-1:W];
                    lo_next = prod_neg[W-1:0];
                end
                done_next  = 1'b1;
                state_next = MD_IDLE;
            end
            default: state_next = MD_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MD_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        b_reg      <= b_next;
        cnt_reg    <= cnt_next;
        is_div_reg <= is_div_next;
        neg_q_reg  <= neg_q_next;
        neg_r_reg  <= neg_r_next;
    end

    assign rsp.done = done_reg;
    assign rsp.hi   = hi_reg;
    assign rsp.lo   = lo_reg;

endmodule

`default_nettype wire

// File: hdl/integer_alu_with_hi_lo_top.sv
// logic, add/sub, compare and refused ops pass through ST_DONE into the output register
// multiply and divide run 32 shift-add or restoring-subtract steps on one shared 33-bit
// adder, one sign fix-up step, then go through ST_RUN and ST_DONE into the output register
// ST_DONE holds while the output register is stalled; a new request is taken only in ST_IDLE
// reset: synchronous active-low aresetn clears HI and LO to zero and empties the output
`timescale 1ns / 1ps
`default_nettype none

module integer_alu_with_hi_lo_top (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire [63:0] s_tdata,   // operand_a [31:0], operand_b [63:32]
    input  wire [3:0]  s_tuser,   // opcode [3:0]
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [95:0] m_tdata,  // result [31:0], hi_value [63:32], lo_value [95:64]
    output logic [1:0] m_tuser    // status [1:0]
);

    localparam int unsigned W = ialu_pkg::DataWidth;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [W-1:0]     res_reg, res_next;
    ialu_pkg::sts_t   sts_reg, sts_next;
    logic [W-1:0]     hi_reg, hi_next;
    logic [W-1:0]     lo_reg, lo_next;
    logic             m_valid_reg, m_valid_next;
    logic [3*W-1:0]   m_data_reg, m_data_next;
    logic [1:0]       m_user_reg, m_user_next;

    ialu_pkg::op_t     op;
    logic [W-1:0]      opa;
    logic [W-1:0]      opb;
    ialu_pkg::alu_rsp_t alu_rsp;
    ialu_pkg::md_req_t md_req;
    ialu_pkg::md_rsp_t md_rsp;
    logic              accept;
    logic              is_mul;
    logic              is_div;

    assign op     = ialu_pkg::op_t'(s_tuser);
    assign opa    = s_tdata[W-1:0];
    assign opb    = s_tdata[2*W-1:W];
    assign accept = s_tvalid && s_tready;

    ialu_alu u_alu (
        .op  (op),
        .a   (opa),
        .b   (opb),
        .rsp (alu_rsp)
    );

    // start the iterative unit for multiply and for divide by nonzero
    assign is_mul = (op == ialu_pkg::OP_MULT) || (op == ialu_pkg::OP_MULTU);
    assign is_div = ((op == ialu_pkg::OP_DIV) || (op == ialu_pkg::OP_DIVU))
                  && (alu_rsp.status == ialu_pkg::STS_OK);
    assign md_req.start     = accept && (is_mul || is_div);
    assign md_req.is_div    = is_div;
    assign md_req.is_signed = (op == ialu_pkg::OP_MULT) || (op == ialu_pkg::OP_DIV);
    assign md_req.a         = opa;
    assign md_req.b         = opb;

    ialu_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (md_req),
        .rsp     (md_rsp)
    );

    assign s_tready = (state_reg == ST_IDLE);

    // control and output register
    always_comb begin
        state_next   = state_reg;
        res_next     = res_reg;
        sts_next     = sts_reg;
        hi_next      = hi_reg;
        lo_next      = lo_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    res_next   = alu_rsp.result;
                    sts_next   = alu_rsp.status;
                    state_next = md_req.start ? ST_RUN : ST_DONE;
                end
            end
            ST_RUN: begin
                if (md_rsp.done) begin
                    hi_next    = md_rsp.hi;
                    lo_next    = md_rsp.lo;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_data_next  = {lo_reg, hi_reg, res_reg};
                    m_user_next  = sts_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            hi_reg      <= '0;
            lo_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            hi_reg      <= hi_next;
            lo_reg      <= lo_next;
            m_valid_reg <= m_valid_next;
        end
        res_reg    <= res_next;
        sts_reg    <= sts_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // one request in flight at a time
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("request accepted while another was in flight");

    // unit answers only while a multiply or divide is pending
    a_done_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        md_rsp.done |-> (state_reg == ST_RUN))
        else $error("multiply/divide answer outside of run state");

    // a finished result is held while the output register is stalled
    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) && m_valid_reg && !m_tready |=> (state_reg == ST_DONE))
        else $error("finished result dropped under stall");

endmodule

`default_nettype wire
